[design/dsp_aru_pkg.sv]
// Shared types, constants and helper functions of the address-register update unit.
package dsp_aru_pkg;

    // Address width of the address registers
    localparam int ADDR_W      = 16;
    // Magnitude of offset plus step: one bit above the address width
    localparam int MAG_W       = ADDR_W + 1;
    // Remainder pipeline: number of stages and trial subtractions per stage
    localparam int DIV_STAGES  = 3;
    localparam int DIV_STEPS   = (MAG_W + DIV_STAGES - 1) / DIV_STAGES;
    // Width of the shifted divisor used in a trial subtraction
    localparam int WIDE_W      = ADDR_W + MAG_W;
    // Pipeline depth: entry stage, remainder stages, output register
    localparam int NSTG        = DIV_STAGES + 2;
    // Input beat: mode, address, step packed from bit 0, padded to bytes
    localparam int MODE_W      = 2;
    localparam int IN_FIELDS_W = MODE_W + 2 * ADDR_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR = 2'd0,
        MODE_CIRC   = 2'd1,
        MODE_BITREV = 2'd2
    } mode_t;

    // One pipeline slot
    typedef struct packed {
        logic              circ;  // circular wrap applies
        logic              neg;   // offset plus step was negative
        logic [ADDR_W-1:0] base;  // address bits above the buffer mask
        logic [MAG_W-1:0]  mag;   // magnitude being reduced modulo size
        logic [ADDR_W-1:0] res;   // result for linear and bit-reversed modes
    } stage_t;

    // Mirror the address bits
    function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        for (int i = 0; i < ADDR_W; i++)
        begin
            r[i] = v[ADDR_W-1-i];
        end
        return r;
    endfunction

    // Smallest all-ones mask covering the buffer size
    function automatic logic [ADDR_W-1:0] smear_mask(input logic [ADDR_W-1:0] size);
        logic [ADDR_W-1:0] m;
        m = size;
        for (int s = 1; s < ADDR_W; s = s * 2)
        begin
            m = m | (m >> s);
        end
        return m;
    endfunction

    // Restoring trial subtractions of size shifted by hi downwards, at most DIV_STEPS
    function automatic logic [MAG_W-1:0] div_steps(input logic [MAG_W-1:0]  rem,
                                                  input logic [ADDR_W-1:0] size,
                                                  input int                hi);
        logic [WIDE_W-1:0] r;
        logic [WIDE_W-1:0] d;
        r = WIDE_W'(rem);
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (hi - j >= 0)
            begin
                d = WIDE_W'(size) << (hi - j);
                if (r >= d)
                begin
                    r = r - d;
                end
            end
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

[design/dsp_address_register_update_top.sv]
// Address-register update unit: linear, circular and bit-reversed address steps.
//
// Usage:
//   Input beats arrive on s_axis_* carrying the mode, the current address and a
//   signed step; one updated address leaves on m_axis_* for every input beat, in
//   order. cfg_we/cfg_wdata load the circular buffer size; write it only while
//   no beat is in flight. A size of zero makes circular mode a plain add.
//   Throughput is one beat per clock while the receiver takes results: the work
//   is spread over an entry stage (mask, offset add, linear and reversed-carry
//   adds), three remainder stages of six or fewer trial subtractions each, and
//   an output register that applies the negative wrap and rejoins the base bits.
//   Reset clears all valid bits and sets the buffer size to zero. When the
//   receiver stalls, the result is held on m_axis_tdata and stages behind it
//   keep filling any empty slots, so s_axis_tready drops only once every
//   stage holds a beat.
module dsp_address_register_update_top
    import dsp_aru_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Buffer size register
    input  logic                  cfg_we,
    input  logic [ADDR_W-1:0]     cfg_wdata,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // mode[1:0], address[17:2], step[33:18]
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [ADDR_W-1:0]     m_axis_tdata   // new_address[15:0]
);

    logic [ADDR_W-1:0]     size_reg;
    logic [NSTG-1:0]       vld_reg;
    logic [NSTG-1:0]       adv;
    stage_t                stage_reg  [0:DIV_STAGES];
    stage_t                stage_next [0:DIV_STAGES];
    logic [ADDR_W-1:0]     out_reg;
    logic [ADDR_W-1:0]     out_next;

    logic [MODE_W-1:0]     in_mode;
    logic [ADDR_W-1:0]     in_addr;
    logic [ADDR_W-1:0]     in_step;
    logic [ADDR_W-1:0]     in_mask;
    logic signed [MAG_W:0] in_sum;
    logic signed [MAG_W:0] in_neg_sum;
    logic [ADDR_W-1:0]     fin_rem;
    logic [ADDR_W-1:0]     fin_wrap;

    // Hold the buffer size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    // Advance a stage when it is empty or the stage ahead advances
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = out_reg;

    // Unpack the input beat
    assign in_mode = s_axis_tdata[MODE_W-1:0];
    assign in_addr = s_axis_tdata[MODE_W +: ADDR_W];
    assign in_step = s_axis_tdata[MODE_W+ADDR_W +: ADDR_W];

    // Entry stage: mask, signed offset sum and the non-circular results
    always_comb
    begin
        in_mask    = smear_mask(size_reg);
        in_sum     = $signed({2'b00, in_addr & in_mask})
                   + $signed({{(MAG_W-ADDR_W+1){in_step[ADDR_W-1]}}, in_step});
        in_neg_sum = -in_sum;

        stage_next[0].circ = (in_mode == MODE_CIRC) && (size_reg != '0);
        stage_next[0].neg  = in_sum[MAG_W];
        stage_next[0].base = in_addr & ~in_mask;
        stage_next[0].mag  = in_sum[MAG_W] ? in_neg_sum[MAG_W-1:0] : in_sum[MAG_W-1:0];
        unique case (in_mode)
            MODE_BITREV: stage_next[0].res = bit_rev(bit_rev(in_addr) + bit_rev(in_step));
            default:     stage_next[0].res = in_addr + in_step;
        endcase

        // Remainder stages: reduce the magnitude modulo the buffer size
        for (int i = 1; i <= DIV_STAGES; i++)
        begin
            stage_next[i]     = stage_reg[i-1];
            stage_next[i].mag = div_steps(stage_reg[i-1].mag, size_reg,
                                          MAG_W - 1 - (i - 1) * DIV_STEPS);
        end
    end

    // Output stage: wrap negative remainders and rejoin the base bits
    always_comb
    begin
        fin_rem  = stage_reg[DIV_STAGES].mag[ADDR_W-1:0];
        fin_wrap = (stage_reg[DIV_STAGES].neg && (fin_rem != '0)) ? size_reg - fin_rem
                                                                  : fin_rem;
        out_next = stage_reg[DIV_STAGES].circ ? (stage_reg[DIV_STAGES].base | fin_wrap)
                                              : stage_reg[DIV_STAGES].res;
    end

    // Move valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Move payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DIV_STAGES; i++)
        begin
            if (adv[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
        if (adv[NSTG-1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

[design/dsp_aru_checker.sv]
// Port-level checks of the address-register update unit, bound to the top level.
module dsp_aru_assertions
    import dsp_aru_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_TDATA_W-1:0] s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [ADDR_W-1:0]     m_axis_tdata
);

    logic s_beat;
    assign s_beat = s_axis_tvalid && s_axis_tready;

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // Show no result in the cycle after reset is seen
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result shown after reset");

    // Refuse input only when every stage is full and the receiver stalls
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused with room in the pipeline");

    // A linear beat with a free-running receiver returns address plus step
    a_linear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && (s_axis_tdata[MODE_W-1:0] == MODE_LINEAR))
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid
            && (m_axis_tdata == ADDR_W'($past(s_axis_tdata[MODE_W +: ADDR_W], 5)
                                      + $past(s_axis_tdata[MODE_W+ADDR_W +: ADDR_W], 5))))
        else $error("linear update mismatch");

endmodule

bind dsp_address_register_update_top dsp_aru_assertions u_dsp_aru_assertions (.*);
